[hdl/mts_pkg.sv]
`default_nettype none
package mts_pkg;

    localparam int KIND_W   = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 11;

    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic ready;
        logic fetch;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic pop_ok;
    } dp_status_t;

endpackage
`default_nettype wire

[hdl/mts_in_if.sv]
`default_nettype none
interface mts_in_if import mts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, kind, item_value, input ready);
    modport sink (input valid, kind, item_value, output ready);
endinterface
`default_nettype wire

[hdl/mts_out_if.sv]
`default_nettype none
interface mts_out_if import mts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;
    logic [FILL_W-1:0]        fill_count;

    modport source (output valid, value, status, fill_count, input ready);
    modport sink (input valid, value, status, fill_count, output ready);
endinterface
`default_nettype wire

[hdl/min_tracking_stack_unit.sv]
`default_nettype none
// Min-tracking stack: a LIFO of signed 32-bit values with a companion stack
// of running minima. Each input beat (push, pop or query) returns one result
// beat with the popped value or current minimum, a status (ok, empty, full)
// and the fill count after the operation. The top value and the minimum are
// cached in registers, so push and query read no memory; a pop of a non-empty
// stack waits in fetch and load states while the new top and minimum come
// back through the registered read port of both stack memories before the
// next beat is taken. A result sits in an output register; the next beat is
// taken once it is free or being emptied. No clearing pass runs after reset.
module min_tracking_stack_unit import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    mts_in_if.sink    in_ch,
    mts_out_if.source out_ch
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    mts_controller u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
`default_nettype wire

[hdl/mts_controller.sv]
`default_nettype none
module mts_controller import mts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd.ready = (state_reg == ST_IDLE) && stat.out_free;
        cmd.fetch = (state_reg == ST_FETCH);
        cmd.load  = (state_reg == ST_LOAD);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.ready && stat.in_valid && stat.pop_ok)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[hdl/mts_datapath.sv]
`default_nettype none
module mts_datapath import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    output dp_status_t stat,
    mts_in_if.sink    in_ch,
    mts_out_if.source out_ch
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic signed [DATA_W-1:0] value_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] min_mem [STACK_DEPTH];

    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            min_count_reg, min_count_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic signed [DATA_W-1:0] cur_min_reg, cur_min_next;
    logic signed [DATA_W-1:0] rd_value_reg, rd_min_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic [FILL_W-1:0]        out_fill_reg;

    logic                     take;
    logic                     is_empty, is_full, push_min;
    logic                     val_wr, min_wr;
    logic signed [DATA_W-1:0] res_value;
    logic [STATUS_W-1:0]      res_status;
    logic [CW-1:0]            count_m1, min_count_m1;

    assign take     = cmd.ready && in_ch.valid;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(STACK_DEPTH));
    assign push_min = is_empty || (min_count_reg == '0) || (in_ch.item_value <= cur_min_reg);
    assign count_m1     = count_reg - 1'b1;
    assign min_count_m1 = min_count_reg - 1'b1;

    assign stat.in_valid = in_ch.valid;
    assign stat.out_free = !out_valid_reg || out_ch.ready;
    assign stat.pop_ok   = (in_ch.kind == KIND_POP) && !is_empty;

    assign in_ch.ready       = cmd.ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.value      = out_value_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.fill_count = out_fill_reg;

    always_comb
    begin
        count_next     = count_reg;
        min_count_next = min_count_reg;
        top_next       = top_reg;
        cur_min_next   = cur_min_reg;
        val_wr         = 1'b0;
        min_wr         = 1'b0;
        res_value      = '0;
        res_status     = STAT_OK;
        if (take)
        begin
            unique case (in_ch.kind)
                KIND_PUSH:
                begin
                    if (is_full)
                    begin
                        res_status = STAT_FULL;
                        res_value  = cur_min_reg;
                    end
                    else
                    begin
                        val_wr     = 1'b1;
                        top_next   = in_ch.item_value;
                        count_next = count_reg + 1'b1;
                        if (push_min)
                        begin
                            min_wr         = 1'b1;
                            min_count_next = min_count_reg + 1'b1;
                            cur_min_next   = in_ch.item_value;
                            res_value      = in_ch.item_value;
                        end
                        else
                        begin
                            res_value = cur_min_reg;
                        end
                    end
                end
                KIND_POP:
                begin
                    if (is_empty)
                    begin
                        res_status = STAT_EMPTY;
                    end
                    else
                    begin
                        res_value  = top_reg;
                        count_next = count_m1;
                        if ((min_count_reg != '0) && (top_reg == cur_min_reg))
                        begin
                            min_count_next = min_count_m1;
                        end
                    end
                end
                default:
                begin
                    if (is_empty || (min_count_reg == '0))
                    begin
                        res_status = STAT_EMPTY;
                    end
                    else
                    begin
                        res_value = cur_min_reg;
                    end
                end
            endcase
        end
        else if (cmd.load)
        begin
            top_next     = rd_value_reg;
            cur_min_next = rd_min_reg;
        end
    end

    // stores; refill reads the new top entries after a pop
    always_ff @(posedge clk)
    begin
        if (val_wr)
        begin
            value_mem[count_reg[AW-1:0]] <= in_ch.item_value;
        end
        if (min_wr)
        begin
            min_mem[min_count_reg[AW-1:0]] <= in_ch.item_value;
        end
        if (cmd.fetch)
        begin
            rd_value_reg <= value_mem[count_m1[AW-1:0]];
            rd_min_reg   <= min_mem[min_count_m1[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            min_count_reg <= min_count_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        cur_min_reg <= cur_min_next;
        if (take)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
            out_fill_reg   <= FILL_W'(count_next);
        end
    end

    a_min_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        min_count_reg <= count_reg)
        else $error("min stack deeper than value stack");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_min_present: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_count_reg != '0))
        else $error("non-empty stack without a minimum");

    a_no_take_in_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fetch || cmd.load) |-> !take)
        else $error("beat taken during refill");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps

import mts_pkg::*;

typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;
    logic [FILL_W-1:0]        fill;
} mts_result_t;

class min_stack_scoreboard;
    int unsigned              depth;
    logic signed [DATA_W-1:0] values[$];
    logic signed [DATA_W-1:0] minima[$];
    mts_result_t              awaited[$];
    int                       errors;

    function new(int unsigned stack_depth);
        depth = stack_depth;
        errors = 0;
    endfunction

    function void note_op(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] item_value);
        mts_result_t r;
        r.value = '0;
        r.status = STAT_OK;
        if (kind == KIND_PUSH)
        begin
            if (values.size() >= depth)
                r.status = STAT_FULL;
            else
            begin
                values.push_back(item_value);
                if (minima.size() == 0 || item_value <= minima[$])
                    minima.push_back(item_value);
            end
            if (minima.size() != 0)
                r.value = minima[$];
        end
        else if (kind == KIND_POP)
        begin
            if (values.size() == 0)
                r.status = STAT_EMPTY;
            else
            begin
                r.value = values.pop_back();
                if (minima.size() != 0 && r.value == minima[$])
                    void'(minima.pop_back());
            end
        end
        else if (values.size() == 0 || minima.size() == 0)
            r.status = STAT_EMPTY;
        else
            r.value = minima[$];
        r.fill = FILL_W'(values.size());
        awaited.push_back(r);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] value, logic [STATUS_W-1:0] status,
                               logic [FILL_W-1:0] fill);
        mts_result_t e;
        if (awaited.size() == 0)
        begin
            $error("unexpected beat: value %0d status %0d fill_count %0d", value, status, fill);
            errors++;
            return;
        end
        e = awaited.pop_front();
        if (value !== e.value)
        begin
            $error("value: expected %0d, got %0d", e.value, value);
            errors++;
        end
        if (status !== e.status)
        begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
        end
        if (fill !== e.fill)
        begin
            $error("fill_count: expected %0d, got %0d", e.fill, fill);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int DEPTH = 1024;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    int   hold_request = 0;

    min_stack_scoreboard sb = new(DEPTH);

    mts_in_if  in_ch();
    mts_out_if out_ch();

    min_tracking_stack_unit #(.STACK_DEPTH(DEPTH)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_op(in_ch.kind, in_ch.item_value);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.value, out_ch.status, out_ch.fill_count);
        end
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else
                out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0, 1:    return int'($urandom_range(16)) - 8;
            2:       return $urandom();
            default:
                case ($urandom_range(3))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic signed [DATA_W-1:0] item_value);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.kind = kind;
        in_ch.item_value = item_value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_random_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 42)
            send_op(KIND_PUSH, pick_value());
        else if (pick < 80)
            send_op(KIND_POP, $urandom());
        else if (pick < 95)
            send_op(KIND_QUERY, $urandom());
        else
            send_op(KIND_SPARE, $urandom());
    endtask

    task automatic wait_all_done();
        in_ch.valid = 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : timeout
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int p;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_PUSH;
        in_ch.item_value = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty stack, extremes, equal minima
        send_op(KIND_QUERY, $urandom());
        send_op(KIND_POP, $urandom());
        send_op(KIND_SPARE, $urandom());
        send_op(KIND_PUSH, VAL_MAX);
        send_op(KIND_PUSH, VAL_MIN);
        send_op(KIND_QUERY, $urandom());
        send_op(KIND_SPARE, $urandom());
        send_op(KIND_PUSH, VAL_MIN);
        send_op(KIND_PUSH, '0);
        send_op(KIND_PUSH, '1);
        send_op(KIND_POP, $urandom());
        send_op(KIND_POP, $urandom());
        send_op(KIND_POP, $urandom());
        send_op(KIND_QUERY, $urandom());
        send_op(KIND_POP, $urandom());
        send_op(KIND_QUERY, $urandom());
        send_op(KIND_POP, $urandom());
        send_op(KIND_POP, $urandom());
        send_op(KIND_PUSH, 32'sd5);
        send_op(KIND_PUSH, 32'sd5);
        send_op(KIND_PUSH, 32'sd7);
        send_op(KIND_PUSH, 32'sd3);
        repeat (4) send_op(KIND_POP, $urandom());
        wait_all_done();

        // long receiver hold-off with input pressure
        hold_request = 250;
        repeat (20) send_op(KIND_PUSH, pick_value());
        repeat (20) send_op(KIND_POP, $urandom());
        wait_all_done();

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 84; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 84; end
                default: begin src_idle_pct = 15; sink_stall_pct = 15; end
            endcase
            repeat (50) send_random_op();
            wait_all_done();
        end

        // drain, then fill to the top with non-increasing values so both stacks fill
        src_idle_pct = 0;
        sink_stall_pct = 0;
        while (sb.values.size() != 0)
            send_op(KIND_POP, $urandom());
        for (i = 0; i < DEPTH; i++)
            send_op(KIND_PUSH, 32'sd1000 - i / 2);
        send_op(KIND_PUSH, VAL_MIN);
        send_op(KIND_PUSH, VAL_MAX);
        send_op(KIND_QUERY, $urandom());
        repeat (4) send_op(KIND_POP, $urandom());
        send_op(KIND_QUERY, $urandom());
        wait_all_done();

        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
